// File: rtl/cmv_pkg.sv
// ----------------------------------------------------------------------------
// cmv_pkg
// shared payload types and verdict codes for the chunk manifest validator
// ----------------------------------------------------------------------------
`default_nettype none

package cmv_pkg;

  typedef struct packed {
    logic        mode;
    logic        last;
    logic        id_nil;
    logic        ref_nil;
    logic        digest_zero;
    logic [63:0] total_length;
    logic [63:0] chunk_key;
    logic [63:0] chunk_offset;
    logic [63:0] logical_len;
    logic [63:0] physical_len;
  } item_t;

  typedef struct packed {
    logic       valid_res;
    logic [2:0] status_class;
    logic [4:0] detail;
    logic [6:0] fail_index;
  } result_t;

  localparam logic MODE_HEADER = 1'b0;
  localparam logic MODE_CHUNK  = 1'b1;

  localparam logic [4:0] D_NONE         = 5'd0;
  localparam logic [4:0] D_MAN_ID_NIL   = 5'd1;
  localparam logic [4:0] D_OBJ_ID_NIL   = 5'd2;
  localparam logic [4:0] D_ZERO_TOTAL   = 5'd3;
  localparam logic [4:0] D_MAN_DIGEST   = 5'd4;
  localparam logic [4:0] D_ORDER        = 5'd5;
  localparam logic [4:0] D_DUP_KEY      = 5'd6;
  localparam logic [4:0] D_CHUNK_NIL    = 5'd7;
  localparam logic [4:0] D_CHUNK_DIGEST = 5'd8;
  localparam logic [4:0] D_ZERO_LOGICAL = 5'd9;
  localparam logic [4:0] D_ZERO_PHYS    = 5'd10;
  localparam logic [4:0] D_OFF_BEYOND   = 5'd11;
  localparam logic [4:0] D_OVERLAP      = 5'd12;
  localparam logic [4:0] D_GAP          = 5'd13;
  localparam logic [4:0] D_EXTENDS      = 5'd14;
  localparam logic [4:0] D_SHORT        = 5'd15;
  localparam logic [4:0] D_NO_CHUNKS    = 5'd16;
  localparam logic [4:0] D_STORE_FULL   = 5'd17;

  localparam logic [2:0] C_OK        = 3'd0;
  localparam logic [2:0] C_MALFORMED = 3'd1;
  localparam logic [2:0] C_INTEGRITY = 3'd2;
  localparam logic [2:0] C_DUPLICATE = 3'd3;
  localparam logic [2:0] C_OVERFLOW  = 3'd4;
  localparam logic [2:0] C_LENGTH    = 3'd5;

  function automatic logic [2:0] class_of(input logic [4:0] d);
    logic [2:0] c;
    case (d) inside
      D_MAN_DIGEST, D_CHUNK_DIGEST: c = C_INTEGRITY;
      D_DUP_KEY:                    c = C_DUPLICATE;
      D_OFF_BEYOND, D_STORE_FULL:   c = C_OVERFLOW;
      D_EXTENDS, D_SHORT:           c = C_LENGTH;
      D_MAN_ID_NIL, D_OBJ_ID_NIL, D_ZERO_TOTAL, D_ORDER, D_CHUNK_NIL,
      D_ZERO_LOGICAL, D_ZERO_PHYS, D_OVERLAP, D_GAP, D_NO_CHUNKS:
                                    c = C_MALFORMED;
      default:                      c = C_OK;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/chunk_manifest_validator.sv
// ----------------------------------------------------------------------------
// chunk_manifest_validator
// checks object manifests and gives one verdict per manifest
// ----------------------------------------------------------------------------
// A header word starts a manifest, chunk words follow, and the word marked
// last yields one verdict word. Words are queued two deep at the input. A
// header is handled in the idle state. While no chunk error has been found,
// a chunk goes through the scan state (one id-store compare per cycle against
// every stored id) and the check state, after that through the idle state
// alone. A verdict waits in the emit state until the output slot is free.
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_manifest_validator
  import cmv_pkg::*;
#(
  parameter int MAX_CHUNKS = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output logic       full,
  input  wire item_t item,
  output logic       empty,
  input  wire logic  pop,
  output result_t    result,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata
);

  logic  gaps_allowed;
  logic  avail;
  logic  take;
  item_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      gaps_allowed <= 1'b0;
    end else if (cfg_we) begin
      gaps_allowed <= cfg_wdata;
    end
  end

  cmv_front u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .item  (item),
    .avail (avail),
    .head  (head),
    .take  (take)
  );

  cmv_back #(.MAX_CHUNKS(MAX_CHUNKS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .gaps_allowed (gaps_allowed),
    .avail        (avail),
    .head         (head),
    .take         (take),
    .empty        (empty),
    .result       (result),
    .pop          (pop)
  );

endmodule

`default_nettype wire

// File: rtl/cmv_front.sv
// ----------------------------------------------------------------------------
// cmv_front
// two-entry input queue that takes words and hands them to the back end
// ----------------------------------------------------------------------------
`default_nettype none

module cmv_front
  import cmv_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output logic       full,
  input  wire item_t item,
  output logic       avail,
  output item_t      head,
  input  wire logic  take
);

  item_t      q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_take;

  assign full    = (cnt == 2'd2);
  assign avail   = (cnt != 2'd0);
  assign head    = q[rp];
  assign do_push = push && !full;
  assign do_take = take && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_take) rp <= ~rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_take};
    end
  end

endmodule

`default_nettype wire

// File: rtl/cmv_back.sv
// ----------------------------------------------------------------------------
// cmv_back
// manifest state, id store scan, per-chunk checks and verdict register
// ----------------------------------------------------------------------------
`default_nettype none

module cmv_back
  import cmv_pkg::*;
#(
  parameter int MAX_CHUNKS = 64
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    gaps_allowed,
  input  wire logic    avail,
  input  wire item_t   head,
  output logic         take,
  output logic         empty,
  output result_t      result,
  input  wire logic    pop
);

  localparam int CW = $clog2(MAX_CHUNKS + 1);
  localparam int AW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam logic [CW-1:0] MAXC = CW'(MAX_CHUNKS);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [63:0]   mem [MAX_CHUNKS];
  logic [63:0]   rd_data;
  logic [1:0]    state;
  item_t         cur;
  logic [CW-1:0] seen_count;
  logic [CW-1:0] idx;
  logic          pend;
  logic [63:0]   coverage_cursor;
  logic [63:0]   object_length;
  logic [63:0]   prior_offset;
  logic [63:0]   prior_key;
  logic [4:0]    header_error;
  logic          order_broken;
  logic [4:0]    first_chunk_error;
  logic          out_valid;

  logic          issue;
  logic          hit;
  logic          slot_free;
  logic          store_ok;
  logic [4:0]    chk;
  logic [4:0]    hdr_err;
  logic [4:0]    verdict;
  logic [63:0]   room;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign take      = (state == ST_IDLE) && avail;
  assign issue     = (idx < seen_count);
  assign hit       = pend && (rd_data == cur.chunk_key);
  assign store_ok  = (seen_count < MAXC);
  assign room      = object_length - cur.chunk_offset;

  always_comb begin
    if (head.id_nil)                  hdr_err = D_MAN_ID_NIL;
    else if (head.ref_nil)            hdr_err = D_OBJ_ID_NIL;
    else if (head.total_length == '0) hdr_err = D_ZERO_TOTAL;
    else if (head.digest_zero)        hdr_err = D_MAN_DIGEST;
    else                              hdr_err = D_NONE;
  end

  always_comb begin
    if (!store_ok)                                  chk = D_STORE_FULL;
    else if (cur.id_nil || cur.ref_nil)             chk = D_CHUNK_NIL;
    else if (cur.digest_zero)                       chk = D_CHUNK_DIGEST;
    else if (cur.logical_len == '0)                 chk = D_ZERO_LOGICAL;
    else if (cur.physical_len == '0)                chk = D_ZERO_PHYS;
    else if (cur.chunk_offset > object_length)      chk = D_OFF_BEYOND;
    else if (cur.chunk_offset < coverage_cursor)    chk = D_OVERLAP;
    else if (!gaps_allowed && cur.chunk_offset != coverage_cursor)
                                                    chk = D_GAP;
    else if (cur.logical_len > room)                chk = D_EXTENDS;
    else                                            chk = D_NONE;
  end

  always_comb begin
    if (header_error != D_NONE)                 verdict = header_error;
    else if (order_broken)                      verdict = D_ORDER;
    else if (first_chunk_error != D_NONE)       verdict = first_chunk_error;
    else if (coverage_cursor != object_length)  verdict = D_SHORT;
    else if (seen_count == '0)                  verdict = D_NO_CHUNKS;
    else                                        verdict = D_NONE;
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[idx[AW-1:0]];
    if (state == ST_CHECK && store_ok) begin
      mem[seen_count[AW-1:0]] <= cur.chunk_key;
    end
  end

  always_ff @(posedge clk) begin
    if (take) cur <= head;
    if (state == ST_EMIT && slot_free) begin
      result.valid_res    <= (verdict == D_NONE);
      result.status_class <= class_of(verdict);
      result.detail       <= verdict;
      result.fail_index   <= (header_error == D_NONE && !order_broken &&
                              first_chunk_error != D_NONE) ? 7'(seen_count) : 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      out_valid         <= 1'b0;
      seen_count        <= '0;
      idx               <= '0;
      pend              <= 1'b0;
      coverage_cursor   <= '0;
      object_length     <= '0;
      prior_offset      <= '0;
      prior_key         <= '0;
      header_error      <= D_NONE;
      order_broken      <= 1'b0;
      first_chunk_error <= D_NONE;
    end else begin
      if (pop && out_valid && state != ST_EMIT) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (avail) begin
            if (head.mode == MODE_HEADER) begin
              seen_count        <= '0;
              coverage_cursor   <= '0;
              object_length     <= head.total_length;
              prior_offset      <= '0;
              prior_key         <= '0;
              header_error      <= hdr_err;
              order_broken      <= 1'b0;
              first_chunk_error <= D_NONE;
              state             <= head.last ? ST_EMIT : ST_IDLE;
            end else begin
              if (head.chunk_offset < prior_offset ||
                  (head.chunk_offset == prior_offset && head.chunk_key < prior_key))
                order_broken <= 1'b1;
              prior_offset <= head.chunk_offset;
              prior_key    <= head.chunk_key;
              if (first_chunk_error != D_NONE) begin
                state <= head.last ? ST_EMIT : ST_IDLE;
              end else begin
                idx   <= '0;
                pend  <= 1'b0;
                state <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          pend <= issue && !hit;
          if (issue) idx <= idx + 1'b1;
          if (hit) begin
            first_chunk_error <= D_DUP_KEY;
            state             <= cur.last ? ST_EMIT : ST_IDLE;
          end else if (!issue && !pend) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          first_chunk_error <= chk;
          if (store_ok) seen_count <= seen_count + 1'b1;
          if (chk == D_NONE) coverage_cursor <= cur.chunk_offset + cur.logical_len;
          state <= cur.last ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid         <= 1'b1;
            seen_count        <= '0;
            coverage_cursor   <= '0;
            object_length     <= '0;
            prior_offset      <= '0;
            prior_key         <= '0;
            header_error      <= D_NONE;
            order_broken      <= 1'b0;
            first_chunk_error <= D_NONE;
            state             <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/cmv_checker.sv
// ----------------------------------------------------------------------------
// cmv_checker
// port-level checks on verdict words, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module cmv_checker
  import cmv_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    full,
  input wire logic    empty,
  input wire logic    pop,
  input wire result_t result
);

  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  a_valid_matches: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.valid_res == (result.detail == D_NONE)))
    else $error("valid_res disagrees with detail");

  a_class_matches: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.status_class == class_of(result.detail)))
    else $error("status class disagrees with detail");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && (result.detail < D_DUP_KEY ||
                (result.detail > D_EXTENDS && result.detail != D_STORE_FULL)))
    |-> (result.fail_index == 7'd0))
    else $error("fail index set for a non-chunk verdict");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting verdict changed");

endmodule

bind chunk_manifest_validator cmv_checker u_cmv_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);

`default_nettype wire
